[hw/rtl/bfr_pkg.sv]
`default_nettype none

package bfr_pkg;

   // Command codes of the request channel.
   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_FRAG  = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   // Status codes of the response channel.
   localparam logic [1:0] ST_INCOMPLETE = 2'd0;
   localparam logic [1:0] ST_COMPLETE   = 2'd1;
   localparam logic [1:0] ST_REJECTED   = 2'd2;
   localparam logic [1:0] ST_DONE       = 2'd3;

   typedef struct packed {
      logic [1:0]  command;
      logic        is_fragment;
      logic [63:0] source_id;
      logic [63:0] ctime_ms;
      logic [63:0] creation_seq;
      logic [31:0] total_length;
      logic [31:0] frag_offset;
      logic [12:0] fragment_length;
      logic [11:0] byte_position;
      logic [7:0]  data_byte;
      logic        has_byte;
      logic [11:0] read_index;
   } bfr_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  read_data;
      logic [12:0] received_count;
   } bfr_rsp_type;

   // Operation handed from the classifier to the execution stage.
   typedef enum logic [2:0] {
      OP_CLEAR  = 3'd0,
      OP_READ   = 3'd1,
      OP_WRITE  = 3'd2,
      OP_CHECK  = 3'd3,
      OP_REJECT = 3'd4
   } bfr_op_kind_type;

   typedef struct packed {
      bfr_op_kind_type kind;
      logic [7:0]      data_byte;
      logic            in_range;
      logic [31:0]     total;
   } bfr_op_type;

endpackage

`default_nettype wire

[hw/rtl/bfr_if.sv]
`default_nettype none

interface bfr_req_if;
   import bfr_pkg::*;

   logic        valid;
   logic        ready;
   bfr_req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface bfr_rsp_if;
   import bfr_pkg::*;

   logic        valid;
   logic        ready;
   bfr_rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[hw/rtl/bundle_fragment_reassembler_unit.sv]
`default_nettype none

// Fragment reassembly engine fed one payload byte per request transaction.
// The req_bus channel carries a command (clear, fragment byte, read byte)
// with the full fragment header; rsp_bus returns exactly one response per
// request: a status, the byte read back and the number of distinct bytes held.
// A classifier checks each header against the open context and pushes an
// operation into a two-entry queue; an execution stage then does the
// received-map read-modify-write and the buffer write or read.
// The execution stage takes one operation at a time from the queue: the
// registered map read is followed by its write-back before the next is taken.
// After reset, and after every clear transaction, the received map is swept
// one entry per cycle over all MAX_PAYLOAD entries; req_bus.ready stays low
// during the sweep. When the receiver stalls, the response is held in its
// output register, the queue fills and req_bus.ready then drops; nothing
// is lost.
module bundle_fragment_reassembler_unit #(
   parameter int MAX_PAYLOAD = 4096
) (
   input  wire logic clock,
   input  wire logic reset,
   bfr_req_if.sink   req_bus,
   bfr_rsp_if.source rsp_bus
);
   import bfr_pkg::*;

   localparam int AW = $clog2(MAX_PAYLOAD);
   localparam int CW = $clog2(MAX_PAYLOAD + 1);
   localparam int QW = $bits(bfr_op_type) + AW;

   logic            push;
   bfr_op_type      push_op;
   logic [AW-1:0]   push_addr;
   logic            queue_full;
   logic            queue_empty;
   logic            pop;
   logic [QW-1:0]   pop_data;
   bfr_op_type      q_op;
   logic [AW-1:0]   q_addr;
   logic            sweep_busy;

   assign {q_op, q_addr} = pop_data;

   bfr_front #(
      .MAX_PAYLOAD(MAX_PAYLOAD),
      .AW(AW)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req(req_bus),
      .queue_full(queue_full),
      .sweep_busy(sweep_busy),
      .push(push),
      .push_op(push_op),
      .push_addr(push_addr)
   );

   bfr_queue #(
      .WIDTH(QW),
      .DEPTH(2)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_data({push_op, push_addr}),
      .full(queue_full),
      .pop(pop),
      .pop_data(pop_data),
      .empty(queue_empty)
   );

   bfr_back #(
      .MAX_PAYLOAD(MAX_PAYLOAD),
      .AW(AW),
      .CW(CW)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .queue_empty(queue_empty),
      .q_op(q_op),
      .q_addr(q_addr),
      .pop(pop),
      .sweep_busy(sweep_busy),
      .rsp(rsp_bus)
   );

endmodule

`default_nettype wire

[hw/rtl/bfr_front.sv]
`default_nettype none

module bfr_front #(
   parameter int MAX_PAYLOAD = 4096,
   parameter int AW = 12
) (
   input  wire logic               clock,
   input  wire logic               reset,
   bfr_req_if.sink                 req,
   input  wire logic               queue_full,
   input  wire logic               sweep_busy,
   output logic                    push,
   output bfr_pkg::bfr_op_type     push_op,
   output logic [AW-1:0]           push_addr
);
   import bfr_pkg::*;

   logic        active_ff, active_in;
   logic [63:0] src_ff, src_in;
   logic [63:0] time_ff, time_in;
   logic [63:0] seq_ff, seq_in;
   logic [31:0] total_ff, total_in;

   logic [31:0] total_eff;
   logic        mismatch;
   logic [32:0] frag_end;
   logic        overrun;
   logic        byte_present;
   logic        pos_bad;
   logic [31:0] addr_wide;

   assign req.ready = !queue_full && !sweep_busy;
   assign push      = req.valid && req.ready;

   // A context that is not yet open takes this header, so it always matches.
   assign total_eff = active_ff ? total_ff : req.payload.total_length;
   assign mismatch  = active_ff && ((src_ff != req.payload.source_id) ||
                                    (time_ff != req.payload.ctime_ms) ||
                                    (seq_ff != req.payload.creation_seq) ||
                                    (total_ff != req.payload.total_length));
   assign frag_end  = {1'b0, req.payload.frag_offset} +
                      33'(req.payload.fragment_length);
   assign overrun   = (frag_end > {1'b0, total_eff}) ||
                      (frag_end > 33'(MAX_PAYLOAD));
   assign byte_present = req.payload.has_byte && (req.payload.fragment_length != 13'd0);
   assign pos_bad   = byte_present &&
                      (13'(req.payload.byte_position) >= req.payload.fragment_length);

   always_comb begin
      push_op.kind      = OP_REJECT;
      push_op.data_byte = req.payload.data_byte;
      push_op.in_range  = 1'b0;
      push_op.total     = total_eff;
      addr_wide         = req.payload.frag_offset + 32'(req.payload.byte_position);
      unique case (req.payload.command)
         CMD_CLEAR: begin
            push_op.kind = OP_CLEAR;
         end
         CMD_READ: begin
            push_op.kind     = OP_READ;
            addr_wide        = 32'(req.payload.read_index);
            push_op.in_range = addr_wide < 32'(MAX_PAYLOAD);
         end
         CMD_FRAG: begin
            if (!req.payload.is_fragment || mismatch || overrun || pos_bad) begin
               push_op.kind = OP_REJECT;
            end else if (byte_present) begin
               push_op.kind = OP_WRITE;
            end else begin
               push_op.kind = OP_CHECK;
            end
         end
         default: begin
            push_op.kind = OP_REJECT;
         end
      endcase
      push_addr = addr_wide[AW-1:0];
   end

   always_comb begin
      active_in = active_ff;
      src_in    = src_ff;
      time_in   = time_ff;
      seq_in    = seq_ff;
      total_in  = total_ff;
      if (push) begin
         if (req.payload.command == CMD_CLEAR) begin
            active_in = 1'b0;
         end else if (req.payload.command == CMD_FRAG && req.payload.is_fragment &&
                      !active_ff) begin
            // The context opens even when this byte is then rejected.
            active_in = 1'b1;
            src_in    = req.payload.source_id;
            time_in   = req.payload.ctime_ms;
            seq_in    = req.payload.creation_seq;
            total_in  = req.payload.total_length;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
      src_ff   <= src_in;
      time_ff  <= time_in;
      seq_ff   <= seq_in;
      total_ff <= total_in;
   end

endmodule

`default_nettype wire

[hw/rtl/bfr_queue.sv]
`default_nettype none

module bfr_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   fill_ff, fill_in;
   logic             do_push;
   logic             do_pop;

   assign full     = fill_ff == (PTR_W + 1)'(DEPTH);
   assign empty    = fill_ff == '0;
   assign pop_data = entries_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/bfr_back.sv]
`default_nettype none

module bfr_back #(
   parameter int MAX_PAYLOAD = 4096,
   parameter int AW = 12,
   parameter int CW = 13
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                queue_empty,
   input  wire bfr_pkg::bfr_op_type q_op,
   input  wire logic [AW-1:0]       q_addr,
   output logic                     pop,
   output logic                     sweep_busy,
   bfr_rsp_if.source                rsp
);
   import bfr_pkg::*;

   typedef enum logic [2:0] {
      ST_SWEEP = 3'b001,
      ST_IDLE  = 3'b010,
      ST_EXEC  = 3'b100
   } back_state_type;

   localparam logic [AW-1:0] LAST_ENTRY = AW'(MAX_PAYLOAD - 1);

   back_state_type state_ff, state_in;
   logic [AW-1:0]  sweep_ff, sweep_in;
   logic [CW-1:0]  count_ff, count_in;
   bfr_op_type     op_ff, op_in;
   logic [AW-1:0]  addr_ff, addr_in;
   logic           rsp_valid_ff, rsp_valid_in;
   bfr_rsp_type    rsp_ff, rsp_in;

   logic           map_mem [MAX_PAYLOAD];
   logic [7:0]     data_mem [MAX_PAYLOAD];
   logic           map_rd_ff;
   logic [7:0]     data_rd_ff;
   logic [AW-1:0]  rd_addr;

   logic           slot_free;
   logic           commit;
   logic           do_write;
   logic           first_arrival;
   logic [CW-1:0]  count_next;
   bfr_rsp_type    result;

   assign slot_free     = !rsp_valid_ff || rsp.ready;
   assign pop           = (state_ff == ST_IDLE) && !queue_empty;
   assign commit        = (state_ff == ST_EXEC) && slot_free;
   assign sweep_busy    = state_ff == ST_SWEEP;
   assign do_write      = op_ff.kind == OP_WRITE;
   assign first_arrival = do_write && !map_rd_ff;
   assign count_next    = count_ff + CW'(first_arrival);
   // While an operation waits in the execute state the same entry is read again.
   assign rd_addr       = (state_ff == ST_IDLE) ? q_addr : addr_ff;

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   always_comb begin
      result.status         = ST_REJECTED;
      result.read_data      = 8'd0;
      result.received_count = 13'(32'(count_ff));
      case (op_ff.kind)
         OP_CLEAR: begin
            result.status         = ST_DONE;
            result.received_count = 13'd0;
         end
         OP_READ: begin
            result.status    = ST_DONE;
            result.read_data = op_ff.in_range ? data_rd_ff : 8'd0;
         end
         OP_WRITE, OP_CHECK: begin
            result.status = (32'(count_next) >= op_ff.total) ? ST_COMPLETE : ST_INCOMPLETE;
            result.received_count = 13'(32'(count_next));
         end
         default: begin
            result.status = ST_REJECTED;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      count_in     = count_ff;
      op_in        = op_ff;
      addr_in      = addr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_SWEEP: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == LAST_ENTRY) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (pop) begin
               op_in    = q_op;
               addr_in  = q_addr;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (commit) begin
               rsp_valid_in = 1'b1;
               rsp_in       = result;
               if (op_ff.kind == OP_CLEAR) begin
                  count_in = '0;
                  sweep_in = '0;
                  state_in = ST_SWEEP;
               end else begin
                  count_in = count_next;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_SWEEP;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff   <= op_in;
      addr_ff <= addr_in;
      rsp_ff  <= rsp_in;
   end

   // Received map: one write port shared by the clearing pass and the execute stage.
   always_ff @(posedge clock) begin
      if (state_ff == ST_SWEEP) begin
         map_mem[sweep_ff] <= 1'b0;
      end else if (commit && first_arrival) begin
         map_mem[addr_ff] <= 1'b1;
      end
      map_rd_ff <= map_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (commit && do_write) begin
         data_mem[addr_ff] <= op_ff.data_byte;
      end
      data_rd_ff <= data_mem[rd_addr];
   end

   a_clear_empties_count : assert property (@(posedge clock) disable iff (reset)
      commit && (op_ff.kind == OP_CLEAR) |=> (count_ff == '0) && (state_ff == ST_SWEEP))
      else $error("count not emptied by a clear transaction");

   a_count_steps : assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (count_ff == $past(count_ff)) || (count_ff == $past(count_ff) + 1'b1) ||
               (count_ff == '0))
      else $error("received count moved by more than one");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(MAX_PAYLOAD))
      else $error("received count beyond buffer size");

   a_pop_loads_exec : assert property (@(posedge clock) disable iff (reset)
      pop |=> (state_ff == ST_EXEC) && (addr_ff == $past(q_addr)))
      else $error("popped operation not loaded into execute stage");

endmodule

`default_nettype wire

[test/tb_bundle_fragment_reassembler_unit.sv]
module tb_bundle_fragment_reassembler_unit;
   import bfr_pkg::*;

   localparam int BUFFER_BYTES = 4096;
   localparam int RANDOM_ITEMS = 1500;
   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int DRAIN_CYCLES = 20;
   localparam int HOLD_OFF_LEN = 80;
   // The block rejects this command code; the package gives it no name.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct {
      logic [63:0] src_id;
      logic [63:0] ctime;
      logic [63:0] cseq;
      logic [31:0] total;
   } bundle_header_type;

   class reassembly_scoreboard_type;
      bit          ctx_open;
      logic [63:0] src_l;
      logic [63:0] time_l;
      logic [63:0] seq_l;
      logic [31:0] total_l;
      logic [12:0] distinct_bytes;
      logic [7:0]  byte_store [BUFFER_BYTES];
      bit          seen_map [BUFFER_BYTES];
      bit          ever_written [BUFFER_BYTES];
      int          written_list [$];
      bfr_rsp_type pending_rsps [$];
      int          mismatch_count;

      function new();
         mismatch_count = 0;
         clear_context();
      endfunction

      function void clear_context();
         ctx_open = 1'b0;
         src_l = '0;
         time_l = '0;
         seq_l = '0;
         total_l = '0;
         distinct_bytes = '0;
         foreach (seen_map[i]) seen_map[i] = 1'b0;
      endfunction

      function bfr_rsp_type predict_response(bfr_req_type rq);
         bfr_rsp_type r;
         logic [33:0] span;
         logic [33:0] addr;
         bit          hdr_differs;
         r = '0;
         case (rq.command)
            CMD_CLEAR: begin
               clear_context();
               r.status = ST_DONE;
            end
            CMD_READ: begin
               r.status = ST_DONE;
               if (rq.read_index < BUFFER_BYTES) r.read_data = byte_store[rq.read_index];
            end
            CMD_FRAG: begin
               if (!rq.is_fragment) begin
                  r.status = ST_REJECTED;
               end else begin
                  // The first fragment opens the context even if it is rejected below.
                  if (!ctx_open) begin
                     ctx_open = 1'b1;
                     src_l = rq.source_id;
                     time_l = rq.ctime_ms;
                     seq_l = rq.creation_seq;
                     total_l = rq.total_length;
                     distinct_bytes = '0;
                  end
                  hdr_differs = (src_l != rq.source_id) || (time_l != rq.ctime_ms) ||
                                (seq_l != rq.creation_seq) || (total_l != rq.total_length);
                  span = 34'(rq.frag_offset) + 34'(rq.fragment_length);
                  if (hdr_differs || span > 34'(total_l) || span > BUFFER_BYTES ||
                      (rq.has_byte && rq.fragment_length != 0 &&
                       13'(rq.byte_position) >= rq.fragment_length)) begin
                     r.status = ST_REJECTED;
                  end else begin
                     if (rq.has_byte && rq.fragment_length != 0) begin
                        addr = 34'(rq.frag_offset) + 34'(rq.byte_position);
                        if (addr < BUFFER_BYTES) begin
                           byte_store[addr] = rq.data_byte;
                           if (!ever_written[addr]) begin
                              ever_written[addr] = 1'b1;
                              written_list.push_back(int'(addr));
                           end
                           if (!seen_map[addr]) begin
                              seen_map[addr] = 1'b1;
                              distinct_bytes = distinct_bytes + 13'd1;
                           end
                        end
                     end
                     r.status = (32'(distinct_bytes) >= total_l) ? ST_COMPLETE : ST_INCOMPLETE;
                  end
               end
            end
            default: r.status = ST_REJECTED;
         endcase
         r.received_count = distinct_bytes;
         return r;
      endfunction

      function void note_request(bfr_req_type rq);
         pending_rsps.push_back(predict_response(rq));
      endfunction

      function void check_response(bfr_rsp_type got);
         bfr_rsp_type exp;
         if (pending_rsps.size() == 0) begin
            $error("response with none outstanding: status %0d, read_data %0d, received_count %0d",
                   got.status, got.read_data, got.received_count);
            mismatch_count++;
            return;
         end
         exp = pending_rsps.pop_front();
         if (got.status !== exp.status) begin
            $error("status: expected %0d, actual %0d", exp.status, got.status);
            mismatch_count++;
         end
         if (got.read_data !== exp.read_data) begin
            $error("read_data: expected %0d, actual %0d", exp.read_data, got.read_data);
            mismatch_count++;
         end
         if (got.received_count !== exp.received_count) begin
            $error("received_count: expected %0d, actual %0d",
                   exp.received_count, got.received_count);
            mismatch_count++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycle_count = 0;
   int   req_count = 0;
   int   req_gap_max = 10;
   int   rsp_gap_max = 10;
   int   hold_off_cycles = 0;

   reassembly_scoreboard_type reasm_sb = new();

   bfr_req_if req_bus ();
   bfr_rsp_if rsp_bus ();

   bundle_fragment_reassembler_unit #(
      .MAX_PAYLOAD(BUFFER_BYTES)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_bundle_fragment_reassembler_unit: done, errors");
         $finish;
      end
   end

   function automatic bfr_req_type random_request();
      bfr_req_type rq;
      rq.command = 2'($urandom_range(0, 3));
      rq.is_fragment = 1'($urandom);
      rq.source_id = {$urandom, $urandom};
      rq.ctime_ms = {$urandom, $urandom};
      rq.creation_seq = {$urandom, $urandom};
      rq.total_length = $urandom;
      rq.frag_offset = $urandom;
      rq.fragment_length = 13'($urandom_range(0, 4096));
      rq.byte_position = 12'($urandom);
      rq.data_byte = 8'($urandom);
      rq.has_byte = 1'($urandom);
      rq.read_index = 12'($urandom);
      return rq;
   endfunction

   function automatic bfr_req_type command_item(logic [1:0] cmd);
      bfr_req_type rq;
      rq = random_request();
      rq.command = cmd;
      return rq;
   endfunction

   function automatic bfr_req_type read_item(int idx);
      bfr_req_type rq;
      rq = command_item(CMD_READ);
      rq.read_index = 12'(idx);
      return rq;
   endfunction

   function automatic bundle_header_type random_header(logic [31:0] total);
      bundle_header_type h;
      h.src_id = {$urandom, $urandom};
      h.ctime = {$urandom, $urandom};
      h.cseq = {$urandom, $urandom};
      h.total = total;
      return h;
   endfunction

   function automatic bfr_req_type frag_item(bundle_header_type h, logic [31:0] off,
                                             logic [12:0] flen, logic [11:0] pos,
                                             logic [7:0] data, logic has);
      bfr_req_type rq;
      rq = command_item(CMD_FRAG);
      rq.is_fragment = 1'b1;
      rq.source_id = h.src_id;
      rq.ctime_ms = h.ctime;
      rq.creation_seq = h.cseq;
      rq.total_length = h.total;
      rq.frag_offset = off;
      rq.fragment_length = flen;
      rq.byte_position = pos;
      rq.data_byte = data;
      rq.has_byte = has;
      return rq;
   endfunction

   // Malformed or unrelated transaction to sprinkle into an open bundle.
   function automatic bfr_req_type noise_item(bundle_header_type h);
      bfr_req_type       rq;
      bundle_header_type bad;
      int                kind;
      int                lim;
      int                bit_sel;
      kind = $urandom_range(0, 6);
      lim = (h.total > 12) ? 12 : int'(h.total);
      rq = frag_item(h, 32'd0, 13'($urandom_range(0, lim)), 12'd0, 8'($urandom), 1'b1);
      bit_sel = $urandom_range(0, 63);
      case (kind)
         0: begin
            if (reasm_sb.written_list.size() > 0)
               rq = read_item(reasm_sb.written_list[
                       $urandom_range(0, reasm_sb.written_list.size() - 1)]);
            else
               rq.is_fragment = 1'b0;
         end
         1: rq.is_fragment = 1'b0;
         2: begin
            bad = h;
            case ($urandom_range(0, 3))
               0: bad.src_id[bit_sel] = ~bad.src_id[bit_sel];
               1: bad.ctime[bit_sel] = ~bad.ctime[bit_sel];
               2: bad.cseq[bit_sel] = ~bad.cseq[bit_sel];
               default: bad.total[bit_sel % 32] = ~bad.total[bit_sel % 32];
            endcase
            rq = frag_item(bad, rq.frag_offset, rq.fragment_length, rq.byte_position,
                           rq.data_byte, rq.has_byte);
         end
         3: begin
            rq.frag_offset = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom;
            rq.fragment_length = 13'($urandom_range(1, 4096));
         end
         4: begin
            rq.fragment_length = 13'($urandom_range(1, 12));
            rq.byte_position = 12'($urandom_range(int'(rq.fragment_length), 4095));
         end
         5: rq.has_byte = 1'b0;
         default: rq.command = CMD_UNUSED;
      endcase
      return rq;
   endfunction

   task automatic send_request(input bfr_req_type rq);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.payload <= rq;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      reasm_sb.note_request(rq);
      if (rq.command != CMD_UNUSED) req_count++;
   endtask

   // Response side: random stalls per transaction, plus an occasional long hold-off.
   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      forever begin
         if (hold_off_cycles > 0) begin
            stall = hold_off_cycles;
            hold_off_cycles = 0;
         end else begin
            stall = $urandom_range(0, rsp_gap_max);
         end
         if (stall > 0) begin
            @(negedge clock);
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         @(negedge clock);
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         reasm_sb.check_response(rsp_bus.payload);
      end
   end

   initial begin
      bundle_header_type hdr;
      bundle_header_type bad;
      int                random_start;
      int                bundle_count;
      req_bus.valid = 1'b0;
      req_bus.payload = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Directed corner cases.
      send_request(command_item(CMD_CLEAR));
      hdr = random_header(32'd0);
      send_request(frag_item(hdr, 32'd0, 13'd0, 12'd0, 8'd0, 1'b0));
      send_request(command_item(CMD_CLEAR));
      hdr = random_header(32'd4096);
      send_request(frag_item(hdr, 32'd0, 13'd4096, 12'd4095, 8'hFF, 1'b1));
      send_request(frag_item(hdr, 32'd0, 13'd4096, 12'd0, 8'h00, 1'b1));
      send_request(frag_item(hdr, 32'd0, 13'd4096, 12'd4095, 8'hA5, 1'b1));
      begin
         bfr_req_type rq;
         rq = frag_item(hdr, 32'd0, 13'd4, 12'd1, 8'h5A, 1'b1);
         rq.is_fragment = 1'b0;
         send_request(rq);
      end
      bad = hdr; bad.src_id[63] = ~bad.src_id[63];
      send_request(frag_item(bad, 32'd0, 13'd4, 12'd1, 8'h11, 1'b1));
      bad = hdr; bad.ctime[0] = ~bad.ctime[0];
      send_request(frag_item(bad, 32'd0, 13'd4, 12'd1, 8'h22, 1'b1));
      bad = hdr; bad.cseq[31] = ~bad.cseq[31];
      send_request(frag_item(bad, 32'd0, 13'd4, 12'd1, 8'h33, 1'b1));
      bad = hdr; bad.total = 32'd4095;
      send_request(frag_item(bad, 32'd0, 13'd4, 12'd1, 8'h44, 1'b1));
      send_request(frag_item(hdr, 32'd4000, 13'd200, 12'd3, 8'h55, 1'b1));
      send_request(frag_item(hdr, 32'd0, 13'd10, 12'd10, 8'h66, 1'b1));
      send_request(frag_item(hdr, 32'd20, 13'd5, 12'd2, 8'h77, 1'b0));
      send_request(command_item(CMD_UNUSED));
      send_request(read_item(4095));
      send_request(read_item(0));
      // A huge total opens the context; the first byte overruns the buffer.
      send_request(command_item(CMD_CLEAR));
      hdr = random_header(32'hFFFF_FFFF);
      send_request(frag_item(hdr, 32'hFFFF_F000, 13'd16, 12'd0, 8'h88, 1'b1));
      send_request(frag_item(hdr, 32'hFFFF_FFFF, 13'd1, 12'd0, 8'h99, 1'b1));
      send_request(frag_item(hdr, 32'd0, 13'd1, 12'd0, 8'hC3, 1'b1));
      send_request(read_item(0));
      send_request(command_item(CMD_CLEAR));
      hdr = random_header(32'd1);
      send_request(frag_item(hdr, 32'd0, 13'd1, 12'd0, 8'h3C, 1'b1));

      // Random bundles, each opened by a clear, with noise mixed in.
      random_start = req_count;
      bundle_count = 0;
      while (req_count - random_start < RANDOM_ITEMS) begin
         int  frag_off [$];
         int  frag_len [$];
         int  off;
         int  flen;
         int  nbytes;
         int  j;
         int  tmp;
         int  pick;
         bit  wide;
         bit  stress;
         bit  reverse;
         bit  first_sent;
         logic [31:0] total;
         logic [11:0] pos;

         stress = (bundle_count % 15 == 5);
         bundle_count++;
         req_gap_max = (stress || $urandom_range(0, 3) == 0) ? 0 : 10;
         rsp_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
         wide = 1'b0;
         pick = $urandom_range(0, 19);
         if (stress) begin
            total = 32'd40;
         end else if (pick == 0) begin
            total = 32'd0;
         end else if (pick == 1) begin
            total = 32'd4096;
            wide = 1'b1;
         end else if (pick == 2) begin
            total = $urandom | 32'h0000_1000;
            wide = 1'b1;
         end else begin
            total = 32'($urandom_range(1, 40));
         end
         hdr = random_header(total);
         send_request(command_item(CMD_CLEAR));

         if (wide) begin
            repeat (3) begin
               if (total == 32'd4096 && $urandom_range(0, 3) == 0) begin
                  flen = 4096;
                  off = 0;
               end else begin
                  flen = $urandom_range(1, 16);
                  off = $urandom_range(0, BUFFER_BYTES - flen);
               end
               frag_off.push_back(off);
               frag_len.push_back(flen);
            end
         end else if (total == 0) begin
            frag_off.push_back(0);
            frag_len.push_back(0);
         end else begin
            off = 0;
            while (off < int'(total)) begin
               flen = $urandom_range(1, (int'(total) - off > 12) ? 12 : int'(total) - off);
               frag_off.push_back(off);
               frag_len.push_back(flen);
               off += flen;
            end
         end
         for (int i = 0; i < frag_off.size(); i++) begin
            j = $urandom_range(0, frag_off.size() - 1);
            tmp = frag_off[i]; frag_off[i] = frag_off[j]; frag_off[j] = tmp;
            tmp = frag_len[i]; frag_len[i] = frag_len[j]; frag_len[j] = tmp;
         end
         // An overlapping retransmission must not be counted twice.
         if ($urandom_range(0, 3) == 0) begin
            j = $urandom_range(0, frag_off.size() - 1);
            frag_off.push_back(frag_off[j]);
            frag_len.push_back(frag_len[j]);
         end

         first_sent = 1'b0;
         for (int f = 0; f < frag_off.size(); f++) begin
            flen = frag_len[f];
            if (flen == 0 || $urandom_range(0, 15) == 0) begin
               send_request(frag_item(hdr, 32'(frag_off[f]), 13'(flen), 12'($urandom),
                                      8'($urandom), (flen == 0) ? 1'($urandom) : 1'b0));
               first_sent = 1'b1;
            end else begin
               nbytes = (flen > 8 && wide) ? 8 : flen;
               reverse = 1'($urandom);
               for (int k = 0; k < nbytes; k++) begin
                  if (first_sent && $urandom_range(0, 7) == 0) send_request(noise_item(hdr));
                  if (flen > nbytes) pos = 12'($urandom_range(0, flen - 1));
                  else pos = reverse ? 12'(flen - 1 - k) : 12'(k);
                  send_request(frag_item(hdr, 32'(frag_off[f]), 13'(flen), pos,
                                         8'($urandom), 1'b1));
                  // Stall the response side while bytes keep coming back to back.
                  if (!first_sent && stress) hold_off_cycles = HOLD_OFF_LEN;
                  first_sent = 1'b1;
               end
            end
         end
         if ($urandom_range(0, 1) == 0) begin
            repeat ($urandom_range(1, 3)) begin
               if (reasm_sb.written_list.size() > 0)
                  send_request(read_item(reasm_sb.written_list[
                     $urandom_range(0, reasm_sb.written_list.size() - 1)]));
            end
         end
      end

      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (reasm_sb.pending_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (reasm_sb.mismatch_count == 0 && reasm_sb.pending_rsps.size() == 0) begin
         $display("tb_bundle_fragment_reassembler_unit: done, clean");
      end else begin
         $display("tb_bundle_fragment_reassembler_unit: done, errors");
      end
      $finish;
   end

endmodule
